// ===== rtl/core/lmfb_pkg.sv =====
// lmfb_pkg: shared types and constants of the LED mode / fade / blink controller.
// Used by the controller, state memory, update logic and checker; depends on nothing.
package lmfb_pkg;

    localparam int DUTY_W      = 17;
    localparam int HOLD_W      = 16;
    localparam int DIV_W       = 5;
    localparam int MODE_W      = 4;
    localparam int OUT_LEDS    = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 17;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF           = 4'd0,
        MODE_ON            = 4'd1,
        MODE_FAST_ON       = 4'd2,
        MODE_FAST_OFF      = 4'd3,
        MODE_DIM1          = 4'd4,
        MODE_DIM10         = 4'd5,
        MODE_DIM50         = 4'd6,
        MODE_DIM75         = 4'd7,
        MODE_FLASH         = 4'd8,
        MODE_FAST_FLASH    = 4'd9,
        MODE_FASTEST_FLASH = 4'd10,
        MODE_PULSE         = 4'd11
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PWM_PERIOD         = 3'd0,
        CFG_FLASH_HOLD         = 3'd1,
        CFG_FAST_FLASH_HOLD    = 3'd2,
        CFG_FASTEST_FLASH_HOLD = 3'd3,
        CFG_PULSE_HOLD         = 3'd4
    } t_cfg_idx;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register reset values
    localparam logic [DUTY_W-1:0] PERIOD_RST         = 17'd200;
    localparam logic [HOLD_W-1:0] FLASH_HOLD_RST     = 16'd100;
    localparam logic [HOLD_W-1:0] FAST_HOLD_RST      = 16'd50;
    localparam logic [HOLD_W-1:0] FASTEST_HOLD_RST   = 16'd20;
    localparam logic [HOLD_W-1:0] PULSE_HOLD_RST     = 16'd100;

    // ramp divider limits (ticks per step = limit + 1)
    localparam logic [DIV_W-1:0] LIM_ONOFF = 5'd10;
    localparam logic [DIV_W-1:0] LIM_DIM   = 5'd20;
    localparam logic [DIV_W-1:0] LIM_FLASH = 5'd20;
    localparam logic [DIV_W-1:0] LIM_FAST  = 5'd5;
    localparam logic [DIV_W-1:0] LIM_PULSE = 5'd2;

    // x/10 = (x*RECIP10)>>20 and x/100 = (x*RECIP100)>>24, exact for 17-bit x
    localparam logic [16:0] RECIP10   = 17'd104858;
    localparam int          RECIP10_SH = 20;
    localparam logic [17:0] RECIP100  = 18'd167773;
    localparam int          RECIP100_SH = 24;

    typedef struct packed {
        t_mode                mode;
        logic [DUTY_W-1:0]    tgt;
        logic [HOLD_W-1:0]    hold;
        logic [DIV_W-1:0]     div;
        logic [DUTY_W-1:0]    duty;
    } t_led_state;

    typedef struct packed {
        logic [DUTY_W-1:0] full;
        logic [DUTY_W-1:0] pct1;
        logic [DUTY_W-1:0] pct10;
        logic [DUTY_W-1:0] pct50;
        logic [DUTY_W-1:0] pct75;
    } t_levels;

    typedef struct packed {
        logic [HOLD_W-1:0] flash;
        logic [HOLD_W-1:0] fast;
        logic [HOLD_W-1:0] fastest;
        logic [HOLD_W-1:0] pulse;
    } t_holds;

endpackage

// ===== rtl/core/led_mode_fade_blink_controller.sv =====
// LED mode / fade / blink controller.
// Items come in on the slave stream; tuser is the opcode: set mode of one LED or tick all.
// A set-mode item names an LED and a mode; a tick advances every LED by one PWM update.
// Each item returns one result on the master stream: four compare values and four modes.
// Config registers (period, flash holds, pulse hold) go through i_cfg_we/addr/wdata;
// the user must write them only while no item is in flight; the block does not enforce it.
// Per-LED state sits in one memory read and written back once per LED an item touches:
// a set item needs one memory access, a tick needs LED_COUNT accesses, one per cycle
// while the buffer has room. Set items are taken one per cycle while it has room; a tick
// holds the sequencer until it has issued the access of every LED.
// Results wait in a two-entry buffer; when the receiver stalls, the sequencer holds
// the final memory access of the next item until the buffer has room, and input
// stops once that item is held.
// Reset (synchronous, active low) sets the defaults of every config register, marks all LED
// state as off/zero at once and empties the pipeline.
module led_mode_fade_blink_controller #(
    parameter int LED_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] led_index, [5:2] new_mode, [7:6] zero
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // duty_green, duty_orange, duty_red, duty_blue
                                        // (17 each), mode_green, mode_orange, mode_red,
                                        // mode_blue (4 each), [87:84] zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [16:0] i_cfg_wdata
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int DW = lmfb_pkg::DUTY_W;
    localparam int MW = lmfb_pkg::MODE_W;

    // ---------------- configuration ----------------
    logic [DW-1:0]                r_period;
    logic [lmfb_pkg::HOLD_W-1:0]  r_hold_flash;
    logic [lmfb_pkg::HOLD_W-1:0]  r_hold_fast;
    logic [lmfb_pkg::HOLD_W-1:0]  r_hold_fastest;
    logic [lmfb_pkg::HOLD_W-1:0]  r_hold_pulse;
    logic [DW-1:0]                r_lvl1;
    logic [DW-1:0]                r_lvl10;
    logic [33:0]                  w_p10;
    logic [34:0]                  w_p100;
    logic [18:0]                  w_p3;
    lmfb_pkg::t_levels            w_levels;
    lmfb_pkg::t_holds             w_holds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= lmfb_pkg::PERIOD_RST;
            r_hold_flash   <= lmfb_pkg::FLASH_HOLD_RST;
            r_hold_fast    <= lmfb_pkg::FAST_HOLD_RST;
            r_hold_fastest <= lmfb_pkg::FASTEST_HOLD_RST;
            r_hold_pulse   <= lmfb_pkg::PULSE_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lmfb_pkg::CFG_PWM_PERIOD:         r_period       <= i_cfg_wdata;
                lmfb_pkg::CFG_FLASH_HOLD:         r_hold_flash   <= i_cfg_wdata[15:0];
                lmfb_pkg::CFG_FAST_FLASH_HOLD:    r_hold_fast    <= i_cfg_wdata[15:0];
                lmfb_pkg::CFG_FASTEST_FLASH_HOLD: r_hold_fastest <= i_cfg_wdata[15:0];
                lmfb_pkg::CFG_PULSE_HOLD:         r_hold_pulse   <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // 1% and 10% levels by reciprocal multiply, registered: ready in the cycle after the
    // period, which is before any item reaches the update stage
    assign w_p10  = 34'(r_period) * 34'(lmfb_pkg::RECIP10);
    assign w_p100 = 35'(r_period) * 35'(lmfb_pkg::RECIP100);
    assign w_p3   = 19'(r_period) + {1'b0, r_period, 1'b0};

    always_ff @(posedge i_clk) begin
        r_lvl10 <= DW'(w_p10 >> lmfb_pkg::RECIP10_SH);
        r_lvl1  <= DW'(w_p100 >> lmfb_pkg::RECIP100_SH);
    end

    assign w_levels.full  = r_period;
    assign w_levels.pct1  = r_lvl1;
    assign w_levels.pct10 = r_lvl10;
    assign w_levels.pct50 = {1'b0, r_period[DW-1:1]};
    assign w_levels.pct75 = w_p3[18:2];

    assign w_holds.flash   = r_hold_flash;
    assign w_holds.fast    = r_hold_fast;
    assign w_holds.fastest = r_hold_fastest;
    assign w_holds.pulse   = r_hold_pulse;

    // ---------------- sequencer (issue stage) ----------------
    logic          r_s_valid;
    logic          r_s_op;
    logic [1:0]    r_s_idx;
    logic [3:0]    r_s_mode;
    logic [AW-1:0] r_s_cnt;
    logic          w_s_last;
    logic          w_s_inrange;
    logic          w_s_go;
    logic          w_s_done;
    logic          w_accept;
    logic          w_credit_ok;
    logic [2:0]    w_ob_est;
    logic [1:0]    w_ob_cnt;
    logic          w_pop;
    logic          w_push;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    assign w_s_inrange = (32'(r_s_idx) < LED_COUNT);
    assign w_s_last    = (r_s_op == lmfb_pkg::OP_SET) || (r_s_cnt == AW'(LED_COUNT - 1));
    assign w_pop       = m_axis_tvalid && m_axis_tready;
    // buffer level after this cycle; the item issued now is pushed in the next cycle
    assign w_ob_est    = 3'(w_ob_cnt) + 3'(w_push) - 3'(w_pop);
    assign w_credit_ok = (w_ob_est <= 3'd1);
    assign w_s_go      = r_s_valid && (!w_s_last || w_credit_ok);
    assign w_s_done    = w_s_go && w_s_last;
    assign s_axis_tready = !r_s_valid || w_s_done;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    assign w_rd_en   = w_s_go && ((r_s_op == lmfb_pkg::OP_TICK) || w_s_inrange);
    assign w_rd_addr = (r_s_op == lmfb_pkg::OP_TICK) ? r_s_cnt : AW'(r_s_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_s_cnt   <= '0;
        end else if (w_accept) begin
            r_s_valid <= 1'b1;
            r_s_cnt   <= '0;
        end else if (w_s_done) begin
            r_s_valid <= 1'b0;
        end else if (w_s_go) begin
            r_s_cnt <= r_s_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s_op   <= s_axis_tuser;
            r_s_idx  <= s_axis_tdata[1:0];
            r_s_mode <= s_axis_tdata[5:2];
        end
    end

    // ---------------- update / write-back stage ----------------
    logic                 r_w_valid;
    logic                 r_w_wen;
    logic                 r_w_last;
    logic                 r_w_op;
    logic [3:0]           r_w_mode;
    logic [AW-1:0]        r_w_addr;
    logic                 w_wr_en;
    lmfb_pkg::t_led_state w_cur;
    lmfb_pkg::t_led_state w_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_w_wen   <= 1'b0;
            r_w_last  <= 1'b0;
        end else begin
            r_w_valid <= w_s_go;
            r_w_wen   <= w_rd_en;
            r_w_last  <= w_s_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_go) begin
            r_w_op   <= r_s_op;
            r_w_mode <= r_s_mode;
            r_w_addr <= w_rd_addr;
        end
    end

    assign w_wr_en = r_w_valid && r_w_wen;
    assign w_push  = r_w_valid && r_w_last;

    lmfb_state_mem #(
        .DEPTH (LED_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_cur),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_w_addr),
        .i_wr_data (w_nxt)
    );

    lmfb_update u_upd (
        .i_cur      (w_cur),
        .i_op       (r_w_op),
        .i_new_mode (r_w_mode),
        .i_levels   (w_levels),
        .i_holds    (w_holds),
        .o_nxt      (w_nxt)
    );

    // ---------------- result view ----------------
    logic [DW-1:0] r_duty [LED_COUNT];
    logic [MW-1:0] r_mode [LED_COUNT];
    logic [DW-1:0] n_duty [LED_COUNT];
    logic [MW-1:0] n_mode [LED_COUNT];
    logic [DW-1:0] w_out_duty [lmfb_pkg::OUT_LEDS];
    logic [MW-1:0] w_out_mode [lmfb_pkg::OUT_LEDS];
    logic [lmfb_pkg::OUT_TDATA_W-1:0] w_res;

    always_comb begin
        n_duty = r_duty;
        n_mode = r_mode;
        if (w_wr_en) begin
            n_duty[r_w_addr] = w_nxt.duty;
            n_mode[r_w_addr] = w_nxt.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LED_COUNT; k++) begin
                r_duty[k] <= '0;
                r_mode[k] <= lmfb_pkg::MODE_OFF;
            end
        end else begin
            r_duty <= n_duty;
            r_mode <= n_mode;
        end
    end

    for (genvar gk = 0; gk < lmfb_pkg::OUT_LEDS; gk++) begin : g_out
        if (gk < LED_COUNT) begin : g_led
            assign w_out_duty[gk] = n_duty[gk];
            assign w_out_mode[gk] = n_mode[gk];
        end else begin : g_none
            assign w_out_duty[gk] = '0;
            assign w_out_mode[gk] = '0;
        end
    end

    assign w_res = {4'b0000,
                    w_out_mode[3], w_out_mode[2], w_out_mode[1], w_out_mode[0],
                    w_out_duty[3], w_out_duty[2], w_out_duty[1], w_out_duty[0]};

    lmfb_out_buf #(
        .DW (lmfb_pkg::OUT_TDATA_W)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_cnt   (w_ob_cnt)
    );

endmodule

// ===== rtl/core/lmfb_state_mem.sv =====
// lmfb_state_mem: per-LED state memory, one read and one write port, registered read.
// Valid bits stand in for the reset value; a write to the entry being read is forwarded.
// Depends on lmfb_pkg.
module lmfb_state_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output lmfb_pkg::t_led_state  o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  lmfb_pkg::t_led_state  i_wr_data
);

    lmfb_pkg::t_led_state r_mem [DEPTH];
    lmfb_pkg::t_led_state r_rd_raw;
    lmfb_pkg::t_led_state r_fwd_data;
    logic [DEPTH-1:0]     r_vld;
    logic                 r_use_fwd;
    logic                 r_use_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_use_fwd  <= 1'b0;
            r_use_zero <= 1'b1;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                // memory still returns the old word when written in the same cycle
                r_use_fwd  <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_use_zero <= !r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_use_fwd  ? r_fwd_data :
                       r_use_zero ? lmfb_pkg::t_led_state'('0) : r_rd_raw;

endmodule

// ===== rtl/core/lmfb_update.sv =====
// lmfb_update: next state of one LED for a set-mode or a tick item.
// Pure combinational; depends on lmfb_pkg.
module lmfb_update (
    input  lmfb_pkg::t_led_state  i_cur,
    input  logic                  i_op,
    input  logic [3:0]            i_new_mode,
    input  lmfb_pkg::t_levels     i_levels,
    input  lmfb_pkg::t_holds      i_holds,
    output lmfb_pkg::t_led_state  o_nxt
);

    function automatic lmfb_pkg::t_led_state step_to(lmfb_pkg::t_led_state s,
                                                     logic [lmfb_pkg::DIV_W-1:0] lim);
        lmfb_pkg::t_led_state r;
        r = s;
        if (s.duty != s.tgt) begin
            if (s.div >= lim) begin
                r.duty = (s.duty > s.tgt) ? s.duty - 17'd1 : s.duty + 17'd1;
                r.div  = '0;
            end else begin
                r.div = s.div + 5'd1;
            end
        end
        return r;
    endfunction

    // hold, then ramp to the target, then flip the target and reload the hold
    function automatic lmfb_pkg::t_led_state flash_to(lmfb_pkg::t_led_state s,
                                                      logic [lmfb_pkg::DIV_W-1:0] lim,
                                                      logic [lmfb_pkg::HOLD_W-1:0] hold,
                                                      logic [lmfb_pkg::DUTY_W-1:0] full);
        lmfb_pkg::t_led_state r;
        r = s;
        if (s.hold != '0) begin
            r.hold = s.hold - 16'd1;
        end else if (s.duty != s.tgt) begin
            r = step_to(s, lim);
        end else begin
            r.tgt  = (s.tgt != '0) ? '0 : full;
            r.hold = hold;
        end
        return r;
    endfunction

    lmfb_pkg::t_mode w_mode;

    assign w_mode = (i_new_mode > 4'(lmfb_pkg::MODE_PULSE)) ? lmfb_pkg::MODE_OFF
                                                             : lmfb_pkg::t_mode'(i_new_mode);

    always_comb begin
        o_nxt = i_cur;
        if (i_op == lmfb_pkg::OP_SET) begin
            // same mode again is a no-op, except pulse which restarts
            if (!(i_cur.mode == w_mode && w_mode != lmfb_pkg::MODE_PULSE)) begin
                case (w_mode)
                    lmfb_pkg::MODE_DIM1:  o_nxt.tgt = i_levels.pct1;
                    lmfb_pkg::MODE_DIM10: o_nxt.tgt = i_levels.pct10;
                    lmfb_pkg::MODE_DIM50: o_nxt.tgt = i_levels.pct50;
                    lmfb_pkg::MODE_DIM75: o_nxt.tgt = i_levels.pct75;
                    lmfb_pkg::MODE_ON,
                    lmfb_pkg::MODE_FAST_ON: o_nxt.tgt = i_levels.full;
                    lmfb_pkg::MODE_FLASH,
                    lmfb_pkg::MODE_FAST_FLASH,
                    lmfb_pkg::MODE_FASTEST_FLASH: begin
                        o_nxt.hold = '0;
                        o_nxt.div  = '0;
                    end
                    lmfb_pkg::MODE_PULSE: begin
                        o_nxt.hold = i_holds.pulse;
                        o_nxt.div  = '0;
                        o_nxt.tgt  = i_levels.full;
                    end
                    default: o_nxt.tgt = '0;
                endcase
                o_nxt.mode = w_mode;
            end
        end else begin
            case (i_cur.mode)
                lmfb_pkg::MODE_FASTEST_FLASH:
                    o_nxt = flash_to(i_cur, lmfb_pkg::LIM_FAST, i_holds.fastest, i_levels.full);
                lmfb_pkg::MODE_FAST_FLASH:
                    o_nxt = flash_to(i_cur, lmfb_pkg::LIM_FAST, i_holds.fast, i_levels.full);
                lmfb_pkg::MODE_FLASH:
                    o_nxt = flash_to(i_cur, lmfb_pkg::LIM_FLASH, i_holds.flash, i_levels.full);
                lmfb_pkg::MODE_PULSE: begin
                    if (i_cur.duty != i_cur.tgt) begin
                        o_nxt = step_to(i_cur, lmfb_pkg::LIM_PULSE);
                    end else if (i_cur.hold == '0) begin
                        // hold over: fade out to zero, and drop to off once that is done
                        o_nxt.tgt = '0;
                        if (i_cur.tgt == '0) begin
                            o_nxt.mode = lmfb_pkg::MODE_OFF;
                        end
                    end else begin
                        o_nxt.hold = i_cur.hold - 16'd1;
                    end
                end
                lmfb_pkg::MODE_DIM1,
                lmfb_pkg::MODE_DIM10,
                lmfb_pkg::MODE_DIM50,
                lmfb_pkg::MODE_DIM75: o_nxt = step_to(i_cur, lmfb_pkg::LIM_DIM);
                lmfb_pkg::MODE_ON,
                lmfb_pkg::MODE_OFF: o_nxt = step_to(i_cur, lmfb_pkg::LIM_ONOFF);
                lmfb_pkg::MODE_FAST_ON,
                lmfb_pkg::MODE_FAST_OFF: o_nxt.duty = i_cur.tgt;
                default: o_nxt = i_cur;
            endcase
        end
    end

endmodule

// ===== rtl/core/lmfb_out_buf.sv =====
// lmfb_out_buf: two-entry result buffer (head register plus skid) on the master side.
// Depends on nothing beyond its parameter.
module lmfb_out_buf #(
    parameter int DW = 88
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    output logic [1:0]    o_cnt
);

    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic [DW-1:0] r_d0;
    logic [DW-1:0] r_d1;
    logic          w_pop;

    assign w_pop = (r_cnt != 2'd0) && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: begin
                if (i_push) begin
                    r_d0 <= i_data;
                end
            end
            2'd1: begin
                if (i_push && w_pop) begin
                    r_d0 <= i_data;
                end else if (i_push) begin
                    r_d1 <= i_data;
                end
            end
            default: begin
                if (w_pop) begin
                    r_d0 <= r_d1;
                    if (i_push) begin
                        r_d1 <= i_data;
                    end
                end
            end
        endcase
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_d0;
    assign o_cnt   = r_cnt;

endmodule

// ===== rtl/core/lmfb_checker.sv =====
// lmfb_checker: port-level assertions on the result stream of the controller,
// bound to led_mode_fade_blink_controller. Depends on lmfb_pkg.
module lmfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    localparam logic [3:0] MODE_MAX = 4'(lmfb_pkg::MODE_PULSE);

    // no result may survive a reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71:68] <= MODE_MAX) && (m_axis_tdata[75:72] <= MODE_MAX)
                       && (m_axis_tdata[79:76] <= MODE_MAX) && (m_axis_tdata[83:80] <= MODE_MAX))
        else $error("result carries an undefined mode");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[87:84] == 4'd0))
        else $error("result padding not zero");

endmodule

bind led_mode_fade_blink_controller lmfb_checker u_lmfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
